/* design/stwr_pkg.sv */
// shared types, codes and defaults for the stack with roll engine
package stwr_pkg;

   localparam int DEF_STACK_DEPTH  = 256;
   localparam int DEF_HANDLE_WIDTH = 64;

   localparam int CMD_W        = 3;
   localparam int HANDLE_OUT_W = 64;
   localparam int STATUS_W     = 2;
   localparam int DEPTH_W      = 9;

   // command codes
   localparam logic [CMD_W-1:0] CMD_PUSH       = 3'd0;
   localparam logic [CMD_W-1:0] CMD_DUP        = 3'd1;
   localparam logic [CMD_W-1:0] CMD_DROP       = 3'd2;
   localparam logic [CMD_W-1:0] CMD_ROLL_LEFT  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_ROLL_RIGHT = 3'd4;
   localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd5;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_TOO_FEW = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]        command;
      logic [HANDLE_OUT_W-1:0] handle_in;
   } req_payload_type;

   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic [HANDLE_OUT_W-1:0] top_handle;
      logic [DEPTH_W-1:0]      depth;
   } rsp_payload_type;

   // datapath operations issued by the controller
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LATCH,
      OP_PUSH,
      OP_DUP,
      OP_DROP,
      OP_ROLL_LEFT,
      OP_ROLL_RD,
      OP_ROLL_WR,
      OP_LOAD_TOP,
      OP_CLEAR,
      OP_RESPOND
   } dp_op_type;

   typedef struct packed {
      dp_op_type           op;
      logic [STATUS_W-1:0] status;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic             empty;
      logic             full;
      logic             too_few;
      logic             rsp_busy;
   } dp_status_type;

endpackage

/* design/stack_with_roll_engine_top.sv */
// top level of the stack with roll engine
// Bounded stack of opaque handles (push, dup, drop, roll left, roll right,
// clear), one response transfer per request transfer carrying status, top
// handle and depth. The entries live in one ram used as a circular buffer
// between a base pointer and the entry count, so a roll moves one entry and
// a base pointer rather than the whole stack and takes constant time. The
// response is loaded through the execute and respond states for push, dup,
// clear, unused codes and any refused command; drop and both rolls pass a
// load or roll write state between them, for the registered read of the ram.
// The next request transfer is taken once the controller is back in idle
// after the response is loaded, so only one request is in flight at a time.
// A loaded response waits in its own register, and a new response is held
// back in the respond state only while the previous one has not yet been
// taken. Reset empties the stack at once; no clearing pass is needed since
// entries outside the count never reach the response.
module stack_with_roll_engine_top
   import stwr_pkg::*;
#(
   parameter int STACK_DEPTH  = DEF_STACK_DEPTH,
   parameter int HANDLE_WIDTH = DEF_HANDLE_WIDTH
) (
   input  logic            clock,
   input  logic            reset,
   // request channel
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   // response channel
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   // command and status between sequencer and datapath
   ctrl_cmd_type  ctrl_cmd;
   dp_status_type dp_status;

   // sequencer: one request at a time
   stwr_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .dp_status (dp_status),
      .ctrl_cmd  (ctrl_cmd)
   );

   // store, pointers, top register and response register
   stwr_datapath #(
      .STACK_DEPTH  (STACK_DEPTH),
      .HANDLE_WIDTH (HANDLE_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .ctrl_cmd    (ctrl_cmd),
      .dp_status   (dp_status)
   );

endmodule

/* design/stwr_ram.sv */
// generic single write port, single read port ram with registered read
module stwr_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/stwr_datapath.sv */
// stack datapath: circular entry store, pointers, top register and response register
module stwr_datapath
   import stwr_pkg::*;
#(
   parameter int STACK_DEPTH  = DEF_STACK_DEPTH,
   parameter int HANDLE_WIDTH = DEF_HANDLE_WIDTH
) (
   input  logic            clock,
   input  logic            reset,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload,
   input  ctrl_cmd_type    ctrl_cmd,
   output dp_status_type   dp_status
);

   localparam int PTR_W = $clog2(STACK_DEPTH);
   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;
   localparam logic [PTR_W-1:0] LAST_PTR   = PTR_W'(STACK_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(STACK_DEPTH);
   localparam logic [SUM_W-1:0] DEPTH_SUM  = SUM_W'(STACK_DEPTH);

   logic [CMD_W-1:0]        cmd_ff, cmd_in;
   logic [HANDLE_WIDTH-1:0] handle_ff, handle_in;
   logic [HANDLE_WIDTH-1:0] top_ff, top_in;
   logic [PTR_W-1:0]        base_ff, base_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   rsp_payload_type         rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic                    wr_en;
   logic [PTR_W-1:0]        wr_addr;
   logic [HANDLE_WIDTH-1:0] wr_data;
   logic [PTR_W-1:0]        rd_addr;
   logic [HANDLE_WIDTH-1:0] rd_data;

   logic [SUM_W-1:0] sum_end, sum_top;
   logic [PTR_W-1:0] end_ptr, top_ptr, below_top_ptr, below_base_ptr, after_base_ptr;

   // slot above the top, the top slot and the slots beside the top and the base, wrapped once into the store
   always_comb begin
      sum_end = SUM_W'(base_ff) + SUM_W'(count_ff);
      sum_top = sum_end - SUM_W'(1);
      end_ptr = (sum_end >= DEPTH_SUM) ? PTR_W'(sum_end - DEPTH_SUM) : PTR_W'(sum_end);
      top_ptr = (sum_top >= DEPTH_SUM) ? PTR_W'(sum_top - DEPTH_SUM) : PTR_W'(sum_top);
      below_top_ptr  = (top_ptr == '0) ? LAST_PTR : top_ptr - PTR_W'(1);
      below_base_ptr = (base_ff == '0) ? LAST_PTR : base_ff - PTR_W'(1);
      after_base_ptr = (base_ff == LAST_PTR) ? '0 : base_ff + PTR_W'(1);
   end

   always_comb begin
      cmd_in       = cmd_ff;
      handle_in    = handle_ff;
      top_in       = top_ff;
      base_in      = base_ff;
      count_in     = count_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      wr_en        = 1'b0;
      wr_addr      = end_ptr;
      wr_data      = handle_ff;
      rd_addr      = '0;
      case (ctrl_cmd.op)
         OP_LATCH: begin
            cmd_in    = req_payload.command;
            handle_in = req_payload.handle_in[HANDLE_WIDTH-1:0];
         end
         OP_PUSH: begin
            wr_en    = 1'b1;
            top_in   = handle_ff;
            count_in = count_ff + CNT_W'(1);
         end
         OP_DUP: begin
            wr_en    = 1'b1;
            wr_data  = top_ff;
            count_in = count_ff + CNT_W'(1);
         end
         OP_DROP: begin
            count_in = count_ff - CNT_W'(1);
            rd_addr  = below_top_ptr;
         end
         OP_ROLL_LEFT: begin
            // old top goes below the bottom, entry under it becomes the top
            wr_en   = 1'b1;
            wr_addr = below_base_ptr;
            wr_data = top_ff;
            base_in = below_base_ptr;
            rd_addr = below_top_ptr;
         end
         OP_ROLL_RD: begin
            rd_addr = base_ff;
         end
         OP_ROLL_WR: begin
            // bottom entry lands above the top, base moves up one
            wr_en   = 1'b1;
            wr_data = rd_data;
            top_in  = rd_data;
            base_in = after_base_ptr;
         end
         OP_LOAD_TOP: begin
            top_in = rd_data;
         end
         OP_CLEAR: begin
            count_in = '0;
         end
         OP_RESPOND: begin
            rsp_in.status     = ctrl_cmd.status;
            rsp_in.top_handle = (count_ff == '0) ? '0 : HANDLE_OUT_W'(top_ff);
            rsp_in.depth      = DEPTH_W'(count_ff);
            rsp_valid_in      = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      handle_ff <= handle_in;
      top_ff    <= top_in;
      rsp_ff    <= rsp_in;
      if (reset) begin
         base_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         base_ff      <= base_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   stwr_ram #(
      .WIDTH (HANDLE_WIDTH),
      .DEPTH (STACK_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      dp_status.command  = cmd_ff;
      dp_status.empty    = (count_ff == '0);
      dp_status.full     = (count_ff == FULL_COUNT);
      dp_status.too_few  = (count_ff < CNT_W'(2));
      dp_status.rsp_busy = rsp_valid_ff & ~rsp_ready;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

/* design/stwr_controller.sv */
// stack controller: sequences each command and settles its status
module stwr_controller
   import stwr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type dp_status,
   output ctrl_cmd_type  ctrl_cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_LOAD,
      S_ROLL_WR,
      S_RESP
   } state_type;

   state_type           state_ff, state_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   dp_op_type           op;

   always_comb begin
      state_in  = state_ff;
      status_in = status_ff;
      op        = OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op       = OP_LATCH;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            status_in = ST_OK;
            state_in  = S_RESP;
            case (dp_status.command)
               CMD_PUSH: begin
                  if (dp_status.full) begin
                     status_in = ST_FULL;
                  end else begin
                     op = OP_PUSH;
                  end
               end
               CMD_DUP: begin
                  if (dp_status.empty) begin
                     status_in = ST_EMPTY;
                  end else if (dp_status.full) begin
                     status_in = ST_FULL;
                  end else begin
                     op = OP_DUP;
                  end
               end
               CMD_DROP: begin
                  if (dp_status.empty) begin
                     status_in = ST_EMPTY;
                  end else begin
                     op       = OP_DROP;
                     state_in = S_LOAD;
                  end
               end
               CMD_ROLL_LEFT: begin
                  if (dp_status.too_few) begin
                     status_in = ST_TOO_FEW;
                  end else begin
                     op       = OP_ROLL_LEFT;
                     state_in = S_LOAD;
                  end
               end
               CMD_ROLL_RIGHT: begin
                  if (dp_status.too_few) begin
                     status_in = ST_TOO_FEW;
                  end else begin
                     op       = OP_ROLL_RD;
                     state_in = S_ROLL_WR;
                  end
               end
               CMD_CLEAR: begin
                  op = OP_CLEAR;
               end
               default: begin
               end
            endcase
         end
         S_LOAD: begin
            op       = OP_LOAD_TOP;
            state_in = S_RESP;
         end
         S_ROLL_WR: begin
            op       = OP_ROLL_WR;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!dp_status.rsp_busy) begin
               op       = OP_RESPOND;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         status_ff <= ST_OK;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
      end
   end

   assign req_ready       = (state_ff == S_IDLE);
   assign ctrl_cmd.op     = op;
   assign ctrl_cmd.status = status_ff;

endmodule
